@@ rtl/sdrt_pkg.sv @@
// Shared types and constants for the sorted dated record table.
package sdrt_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int ID_BYTES_DEF    = 8;

  localparam int ID_W    = 64;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 16;
  localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_MONTH    = 3'd1;
  localparam logic [STAT_W-1:0] ST_DAY_ZERO     = 3'd2;
  localparam logic [STAT_W-1:0] ST_DAY_PAST_END = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL         = 3'd4;
  localparam logic [STAT_W-1:0] ST_INDEX_RANGE  = 3'd5;

  typedef struct packed {
    logic        operation;
    logic [63:0] id_text;
    logic [5:0]  day_in;
    logic [3:0]  month_in;
    logic [15:0] year_in;
    logic [5:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    id_out;
    logic [DAY_W-1:0]   day_out;
    logic [MONTH_W-1:0] month_out;
    logic [YEAR_W-1:0]  year_out;
    logic [CNT_W-1:0]   entry_count;
  } rsp_t;

endpackage

@@ rtl/sdrt_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface sdrt_req_if
  import sdrt_pkg::*;
;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdrt_rsp_if
  import sdrt_pkg::*;
;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sorted_dated_record_table_core.sv @@
// Sorted dated record table: ordered insert with date validation, indexed read.
//
// The table keeps up to MAX_ENTRIES records in one RAM, sorted by date then
// identifier. A read passes S_RDAT, which captures the RAM word, then S_FIN;
// an out-of-range index goes straight to S_FIN. An insert passes S_DIV and
// S_CHK; one that fails validation, finds the table full or lands in an empty
// table then goes to S_FIN, and any other successful insert walks S_SHIFT over
// the held entries that sort above it, and S_PLACE if it belongs in slot 0.
// The key comparator walks the table from the top, one RAM read and one write
// per cycle, moving larger entries up one slot. No new transaction is accepted
// until the previous result has been handed to the output register.
module sorted_dated_record_table_core
  import sdrt_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int ID_BYTES    = ID_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  sdrt_req_if.sink         req,
  sdrt_rsp_if.source       rsp,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  localparam int AW     = $clog2(MAX_ENTRIES);
  localparam int KEEP_W = 8 * ID_BYTES;
  localparam int WORD_W = DATE_W + KEEP_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_RDAT  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [12:0] RECIP25 = 13'd5243;

  logic [2:0]         state;
  logic [CNT_W-1:0]   held;
  logic [CNT_W-1:0]   capacity;
  logic [AW-1:0]      ptr;

  logic [KEEP_W-1:0]  id_r;
  logic [5:0]         day_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  year_r;
  logic [11:0]        q25;

  logic [STAT_W-1:0]  res_status;
  logic [WORD_W-1:0]  res_word;
  logic [CNT_W-1:0]   res_count;

  logic               out_valid;
  rsp_t               out_data;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [WORD_W-1:0]  wdata;
  logic [AW-1:0]      raddr;
  logic [WORD_W-1:0]  rd_data;

  logic [WORD_W-1:0]  new_word;
  logic [CNT_W-1:0]   cap_eff;
  logic               full;
  logic               less;
  logic [28:0]        prod;
  logic [16:0]        q25x;
  logic               leap;
  logic [DAY_W-1:0]   mlen;
  logic [STAT_W-1:0]  chk_status;

  sdrt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_data)
  );

  assign new_word = {year_r, month_r, day_r[DAY_W-1:0], id_r};
  assign cap_eff  = (32'(capacity) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : capacity;
  assign full     = held >= cap_eff;
  assign less     = new_word < rd_data;

  assign prod = 29'(year_r) * 29'(RECIP25);
  assign q25x = (17'(q25) << 4) + (17'(q25) << 3) + 17'(q25);
  assign leap = (year_r[1:0] == 2'd0) && ((q25x != 17'(year_r)) || (year_r[3:0] == 4'd0));

  always_comb begin
    case (month_r)
      4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
      4'd2:                    mlen = leap ? 5'd29 : 5'd28;
      default:                 mlen = 5'd31;
    endcase
    if (month_r == 4'd0 || month_r > 4'd12) begin
      chk_status = ST_BAD_MONTH;
    end else if (day_r == 6'd0) begin
      chk_status = ST_DAY_ZERO;
    end else if (day_r > 6'(mlen)) begin
      chk_status = ST_DAY_PAST_END;
    end else if (full) begin
      chk_status = ST_FULL;
    end else begin
      chk_status = ST_OK;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr + AW'(1);
    wdata = rd_data;
    raddr = ptr - AW'(1);
    case (state)
      S_IDLE: begin
        raddr = AW'(req.data.read_index);
      end
      S_CHK: begin
        raddr = AW'(held - 7'd1);
        if (chk_status == ST_OK && held == '0) begin
          we    = 1'b1;
          waddr = '0;
          wdata = new_word;
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        wdata = less ? rd_data : new_word;
      end
      S_PLACE: begin
        we    = 1'b1;
        waddr = '0;
        wdata = new_word;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
      ptr       <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (out_valid && rsp.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            id_r      <= req.data.id_text[63 -: KEEP_W];
            day_r     <= req.data.day_in;
            month_r   <= req.data.month_in;
            year_r    <= req.data.year_in;
            res_word  <= '0;
            res_count <= held;
            if (req.data.operation == OP_READ) begin
              if (7'(req.data.read_index) >= held) begin
                res_status <= ST_INDEX_RANGE;
                state      <= S_FIN;
              end else begin
                res_status <= ST_OK;
                state      <= S_RDAT;
              end
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          q25   <= prod[28:17];
          state <= S_CHK;
        end
        S_CHK: begin
          res_status <= chk_status;
          if (chk_status != ST_OK) begin
            state <= S_FIN;
          end else if (held == '0) begin
            held      <= held + 7'd1;
            res_count <= held + 7'd1;
            state     <= S_FIN;
          end else begin
            ptr   <= AW'(held - 7'd1);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (!less) begin
            held      <= held + 7'd1;
            res_count <= held + 7'd1;
            state     <= S_FIN;
          end else if (ptr == '0) begin
            state <= S_PLACE;
          end else begin
            ptr <= ptr - AW'(1);
          end
        end
        S_PLACE: begin
          held      <= held + 7'd1;
          res_count <= held + 7'd1;
          state     <= S_FIN;
        end
        S_RDAT: begin
          res_word <= rd_data;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid            <= 1'b1;
            out_data.status      <= res_status;
            out_data.id_out      <= ID_W'(res_word[KEEP_W-1:0]) << (ID_W - KEEP_W);
            out_data.day_out     <= res_word[KEEP_W +: DAY_W];
            out_data.month_out   <= res_word[KEEP_W + DAY_W +: MONTH_W];
            out_data.year_out    <= res_word[KEEP_W + DAY_W + MONTH_W +: YEAR_W];
            out_data.entry_count <= res_count;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    32'(held) <= MAX_ENTRIES)
    else $error("held count above table depth");

  a_held_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (held == $past(held) || held == $past(held) + 7'd1))
    else $error("held count changed by more than one");

  a_shift_ptr: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> 7'(ptr) < held)
    else $error("shift pointer outside held entries");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("response raised outside finish step");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_CHK || state == S_SHIFT || state == S_PLACE))
    else $error("RAM write outside insert steps");
`endif

endmodule

@@ rtl/sdrt_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read per cycle.
module sdrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
